[hw/rtl/assert_macros.svh]
// Assertion macros used by the fence check top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset gating
`define FRCC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, without the reset gate
`define FRCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/frcc_pkg.sv]
// Package: types and constants of the fence region containment check.
package frcc_pkg;

	localparam int MAX_BOXES   = 256;
	localparam int MAX_REGIONS = 64;
	localparam int COORD_W     = 32;
	localparam int BOX_AW      = $clog2(MAX_BOXES);
	localparam int RS_AW       = $clog2(MAX_REGIONS + 1);
	localparam int START_W     = 9;
	localparam int RCNT_W      = 7;
	localparam int IDX_W       = 8;
	localparam int SIZE_W      = COORD_W - 1;
	localparam int AREA_W      = 63;
	localparam int PROD_W      = 2 * COORD_W;
	localparam int IN_DATA_W   = 272;
	localparam int OUT_DATA_W  = 72;

	typedef enum logic [1:0] {
		OP_BOX   = 2'd0,
		OP_START = 2'd1,
		OP_CHECK = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_END,
		ST_WALK,
		ST_DRAIN,
		ST_FIN
	} state_t;

	// one box row: x low, x high, y low, y high
	typedef struct packed {
		logic signed [COORD_W-1:0] yh;
		logic signed [COORD_W-1:0] yl;
		logic signed [COORD_W-1:0] xh;
		logic signed [COORD_W-1:0] xl;
	} box_t;

	// clip cell result handed to the area cell
	typedef struct packed {
		logic               valid;
		logic               pos;
		logic [COORD_W-1:0] d;
	} clip_t;

endpackage

[hw/rtl/fence_region_containment_check_top.sv]
// Top level: fence region containment check with box walk pipeline.
//
// channel  | dir | words
// s_*      | in  | write box, write region start, check node
// m_*      | out | one result per input word
// cfg_*    | in  | region_count
//
// A checked node goes through two region start reads, a walk that reads each box
// of its region from the box table, the clip/multiply/accumulate drain and the
// output load; write, no-op and unchecked words go straight to the output load.
// arst_n clears control state and sets the run flag; table contents are undefined
// until written. A stalled output holds the finished word; the block still takes
// a new word once idle, but holds its result until the output is free.
`include "assert_macros.svh"

module fence_region_containment_check_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// index, start_value, box_left, box_right, box_bottom, box_top,
	// node_x, node_y, node_w, node_h, zero pad
	input  logic [frcc_pkg::IN_DATA_W-1:0]      s_tdata,
	// op
	input  logic [1:0]                          s_tuser,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// node_legal, in_region, uncovered_area, run_legal, zero pad
	output logic [frcc_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [frcc_pkg::RCNT_W-1:0]         cfg_data
);
	import frcc_pkg::*;

	state_t state_q, state_d;

	// input unpack
	op_t                       op;
	logic [IDX_W-1:0]          index;
	logic [START_W-1:0]        start_value;
	box_t                      box_in;
	logic signed [COORD_W-1:0] node_x, node_y;
	logic [SIZE_W-1:0]         node_w, node_h;

	assign op          = op_t'(s_tuser);
	assign index       = s_tdata[7:0];
	assign start_value = s_tdata[16:8];
	assign box_in.xl   = s_tdata[48:17];
	assign box_in.xh   = s_tdata[80:49];
	assign box_in.yl   = s_tdata[112:81];
	assign box_in.yh   = s_tdata[144:113];
	assign node_x      = s_tdata[176:145];
	assign node_y      = s_tdata[208:177];
	assign node_w      = s_tdata[239:209];
	assign node_h      = s_tdata[270:240];

	// config register
	logic [RCNT_W-1:0] region_count_q;
	logic [RCNT_W-1:0] count;
	assign cfg_ready = 1'b1;
	assign count = (region_count_q > RCNT_W'(MAX_REGIONS)) ? RCNT_W'(MAX_REGIONS) :
		region_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_count_q <= '0;
		end else if (cfg_valid) begin
			region_count_q <= cfg_data;
		end
	end

	logic accept, checked;
	assign accept  = s_tvalid & s_tready;
	assign checked = (op == OP_CHECK) && (index < {1'b0, count});

	// region start table
	logic [START_W-1:0] rs_mem [MAX_REGIONS+1];
	logic [START_W-1:0] rs_rdata_q;
	logic               rs_rd_en;
	logic [RS_AW-1:0]   rs_rd_addr;
	logic [RS_AW-1:0]   idx_q;

	always_ff @(posedge clk) begin
		if (accept && op == OP_START && index <= IDX_W'(MAX_REGIONS)) begin
			rs_mem[index[RS_AW-1:0]] <= start_value;
		end
		if (rs_rd_en) begin
			rs_rdata_q <= rs_mem[rs_rd_addr];
		end
	end

	// node latch
	logic signed [COORD_W-1:0] nxl_q, nyl_q;
	logic signed [COORD_W:0]   nxh_q, nyh_q;
	logic                      done_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			nxl_q  <= node_x;
			nyl_q  <= node_y;
			nxh_q  <= {node_x[COORD_W-1], node_x} + {2'b00, node_w};
			nyh_q  <= {node_y[COORD_W-1], node_y} + {2'b00, node_h};
			idx_q  <= index[RS_AW-1:0];
			done_q <= s_tlast;
		end
	end

	// walk counter
	logic [START_W-1:0] cnt_q;
	logic               issue;
	assign issue = (cnt_q < rs_rdata_q) && !cnt_q[START_W-1];

	always_ff @(posedge clk) begin
		if (state_q == ST_RD_END) begin
			cnt_q <= rs_rdata_q;
		end else if (state_q == ST_WALK && issue) begin
			cnt_q <= cnt_q + START_W'(1);
		end
	end

	// box table and cell chain
	logic  box_rd_en;
	box_t  box_q;
	logic  box_v_q;
	clip_t clip_x, clip_y;
	logic  area_busy;
	logic signed [AREA_W-1:0] area_q;

	frcc_box_store u_box (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (accept && op == OP_BOX),
		.wr_addr    (index[BOX_AW-1:0]),
		.wr_data    (box_in),
		.rd_en      (box_rd_en),
		.rd_addr    (cnt_q[BOX_AW-1:0]),
		.rd_data_q  (box_q),
		.rd_valid_q (box_v_q)
	);

	frcc_clip_cell u_clip_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (box_v_q),
		.node_lo  (nxl_q),
		.node_hi  (nxh_q),
		.box_lo   (box_q.xl),
		.box_hi   (box_q.xh),
		.out_s1   (clip_x)
	);

	frcc_clip_cell u_clip_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (box_v_q),
		.node_lo  (nyl_q),
		.node_hi  (nyh_q),
		.box_lo   (box_q.yl),
		.box_hi   (box_q.yh),
		.out_s1   (clip_y)
	);

	frcc_area_cell u_area (
		.clk       (clk),
		.arst_n    (arst_n),
		.init      (accept && checked),
		.init_area (node_w * node_h),
		.clip_x    (clip_x),
		.clip_y    (clip_y),
		.busy      (area_busy),
		.area_q    (area_q)
	);

	logic pipe_busy, out_free;
	assign pipe_busy = box_v_q | clip_x.valid | area_busy;
	assign out_free  = !m_tvalid || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = checked ? ST_RD_END : ST_FIN;
			ST_RD_END: state_d = ST_WALK;
			ST_WALK:   if (!issue) state_d = ST_DRAIN;
			ST_DRAIN:  if (!pipe_busy) state_d = ST_FIN;
			ST_FIN:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready   = 1'b0;
		rs_rd_en   = 1'b0;
		rs_rd_addr = idx_q;
		box_rd_en  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				rs_rd_en   = s_tvalid & checked;
				rs_rd_addr = index[RS_AW-1:0];
			end
			ST_RD_END: begin
				rs_rd_en   = 1'b1;
				rs_rd_addr = idx_q + RS_AW'(1);
			end
			ST_WALK:  box_rd_en = issue;
			ST_DRAIN: ;
			ST_FIN:   ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result word and run flag
	logic                     res_legal_q, res_inreg_q, res_run_q, res_done_q;
	logic signed [AREA_W-1:0] res_area_q;
	logic                     run_ok_q;
	logic                     walk_legal;
	assign walk_legal = area_q[AREA_W-1] || (area_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_ok_q <= 1'b1;
		end else if (accept && op == OP_CHECK && !checked) begin
			run_ok_q <= s_tlast ? 1'b1 : run_ok_q;
		end else if (state_q == ST_DRAIN && !pipe_busy) begin
			run_ok_q <= done_q ? 1'b1 : (run_ok_q & walk_legal);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !checked) begin
			res_legal_q <= 1'b1;
			res_inreg_q <= 1'b0;
			res_area_q  <= '0;
			res_run_q   <= run_ok_q;
			res_done_q  <= (op == OP_CHECK) ? s_tlast : 1'b0;
		end else if (state_q == ST_DRAIN && !pipe_busy) begin
			res_legal_q <= walk_legal;
			res_inreg_q <= 1'b1;
			res_area_q  <= area_q;
			res_run_q   <= run_ok_q & walk_legal;
			res_done_q  <= done_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			m_tdata <= {6'b0, res_run_q, res_area_q, res_inreg_q, res_legal_q};
			m_tlast <= res_done_q;
		end
	end

	// checks
	`FRCC_ASSERT(a_drain_no_read, clk, arst_n, state_q == ST_DRAIN |=> !box_rd_en, "read after drain")
	`FRCC_ASSERT(a_idle_empty, clk, arst_n, state_q == ST_IDLE |-> !pipe_busy, "pipeline busy in idle")
	`FRCC_ASSERT(a_accept_leaves, clk, arst_n, accept |=> state_q != ST_IDLE, "accept stayed idle")

endmodule

[hw/rtl/frcc_box_store.sv]
// Box table memory: one write port, one registered read port.
module frcc_box_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [frcc_pkg::BOX_AW-1:0] wr_addr,
	input  frcc_pkg::box_t              wr_data,
	input  logic                        rd_en,
	input  logic [frcc_pkg::BOX_AW-1:0] rd_addr,
	output frcc_pkg::box_t              rd_data_q,
	output logic                        rd_valid_q
);
	import frcc_pkg::*;

	box_t mem [MAX_BOXES];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// read word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= rd_en;
		end
	end

endmodule

[hw/rtl/frcc_clip_cell.sv]
// Clip cell: overlap length of the node and one box along one axis.
module frcc_clip_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [frcc_pkg::COORD_W-1:0] node_lo,
	input  logic signed [frcc_pkg::COORD_W:0]   node_hi,
	input  logic signed [frcc_pkg::COORD_W-1:0] box_lo,
	input  logic signed [frcc_pkg::COORD_W-1:0] box_hi,
	output frcc_pkg::clip_t                    out_s1
);
	import frcc_pkg::*;

	logic signed [COORD_W:0]   box_hi_x;
	logic signed [COORD_W:0]   box_lo_x;
	logic signed [COORD_W:0]   node_lo_x;
	logic signed [COORD_W:0]   hi;
	logic signed [COORD_W:0]   lo;
	logic signed [COORD_W+1:0] d;
	logic                      valid_s1;
	logic                      pos_s1;
	logic [COORD_W-1:0]        d_s1;

	// min of the highs minus max of the lows, all compares signed
	always_comb begin
		box_hi_x  = {box_hi[COORD_W-1], box_hi};
		box_lo_x  = {box_lo[COORD_W-1], box_lo};
		node_lo_x = {node_lo[COORD_W-1], node_lo};
		hi = (node_hi < box_hi_x) ? node_hi : box_hi_x;
		lo = (node_lo_x > box_lo_x) ? node_lo_x : box_lo_x;
		d  = {hi[COORD_W], hi} - {lo[COORD_W], lo};
	end

	// hand to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= !d[COORD_W+1] && (d != '0);
		d_s1   <= d[COORD_W-1:0];
	end

	assign out_s1 = {valid_s1, pos_s1, d_s1};

endmodule

[hw/rtl/frcc_area_cell.sv]
// Area cell: overlap product, then saturating subtract from the node area.
module frcc_area_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              init,
	input  logic [2*frcc_pkg::SIZE_W-1:0]     init_area,
	input  frcc_pkg::clip_t                   clip_x,
	input  frcc_pkg::clip_t                   clip_y,
	output logic                              busy,
	output logic signed [frcc_pkg::AREA_W-1:0] area_q
);
	import frcc_pkg::*;

	localparam logic signed [AREA_W+2:0] AREA_MIN = -((AREA_W+3)'(1) <<< (AREA_W-1));

	logic [PROD_W-1:0]       prod_s1;
	logic                    hit_s1;
	logic signed [AREA_W+2:0] diff;

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else begin
			hit_s1 <= clip_x.valid & clip_x.pos & clip_y.pos;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= clip_x.d * clip_y.d;
	end

	assign busy = hit_s1;

	// subtract with floor at the lowest area
	always_comb begin
		diff = {{3{area_q[AREA_W-1]}}, area_q} - {2'b00, prod_s1};
	end

	always_ff @(posedge clk) begin
		if (init) begin
			area_q <= AREA_W'(init_area);
		end else if (hit_s1) begin
			area_q <= (diff < AREA_MIN) ? AREA_MIN[AREA_W-1:0] : diff[AREA_W-1:0];
		end
	end

endmodule
